>>> src/dvd_pkg.sv
// shared types, constants and tables for the date validate and day number block
`default_nettype none
package dvd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 23;
  localparam int STAT_W  = 2;
  localparam int OFFS_W  = 9;
  localparam int LEN_W   = 5;
  localparam int Q100_W  = 8;

  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_YEAR_FLOOR   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_YEAR = 2'd1;

  localparam logic [YEAR_W-1:0] YEAR_FLOOR_RESET   = 14'd1500;
  localparam logic [YEAR_W-1:0] CURRENT_YEAR_RESET = 14'd2023;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD_YEAR  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_MONTH = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_BAD_DAY   = 2'd3;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for any 14-bit x
  localparam logic [YEAR_W-1:0] RECIP_100   = 14'd10486;
  localparam int                RECIP_SHIFT = 20;
  localparam int                PROD_W      = 2 * YEAR_W;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // (153 * tm - 457) / 5 with january and february shifted to months 13 and 14,
  // and month 0 taken as month 12
  function automatic logic [OFFS_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [OFFS_W-1:0] offs;
    case (m)
      4'd0:    offs = 9'd275;
      4'd1:    offs = 9'd306;
      4'd2:    offs = 9'd337;
      4'd3:    offs = 9'd0;
      4'd4:    offs = 9'd31;
      4'd5:    offs = 9'd61;
      4'd6:    offs = 9'd92;
      4'd7:    offs = 9'd122;
      4'd8:    offs = 9'd153;
      4'd9:    offs = 9'd184;
      4'd10:   offs = 9'd214;
      4'd11:   offs = 9'd245;
      4'd12:   offs = 9'd275;
      4'd13:   offs = 9'd306;
      4'd14:   offs = 9'd337;
      default: offs = 9'd367;
    endcase
    return offs;
  endfunction

  // length of a common-year month
  function automatic logic [LEN_W-1:0] month_length(input logic [MONTH_W-1:0] m);
    logic [LEN_W-1:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

>>> src/date_validate_and_day_number.sv
// top level: date pair check and day number conversion
//
// command channel: an item (two dates a and b) transfers at a rising edge with
// start high and busy low; busy is never raised, so an item can transfer every
// cycle
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// the lowest valid year, index 1 is current_year, other indexes are ignored;
// cfg_ready is always high; write only while no item is in flight
// result: status_a, status_b, day_count_a, day_count_b and day_difference are
// shown for one cycle with done high; the receiver cannot stall, every result
// transfers at the edge ending that cycle
// throughput is one item per cycle, set by one input register and one result
// register with the range checks and day number sums between them
// reset: synchronous, clears the pipeline valid flags and loads the lowest
// valid year 1500 and current_year 2023
`default_nettype none
module date_validate_and_day_number
  import dvd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic [YEAR_W-1:0]          year_a,
  input  logic [MONTH_W-1:0]         month_a,
  input  logic [DAY_W-1:0]           day_a,
  input  logic [YEAR_W-1:0]          year_b,
  input  logic [MONTH_W-1:0]         month_b,
  input  logic [DAY_W-1:0]           day_b,
  // config channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [YEAR_W-1:0]          cfg_data,
  // result channel
  output logic                       done,
  output logic [STAT_W-1:0]          status_a,
  output logic [STAT_W-1:0]          status_b,
  output logic signed [COUNT_W-1:0]  day_count_a,
  output logic signed [COUNT_W-1:0]  day_count_b,
  output logic signed [COUNT_W-1:0]  day_difference
);

  // config registers
  logic [YEAR_W-1:0]  year_floor;
  logic [YEAR_W-1:0]  current_year;

  // input register
  logic               in_valid;
  date_t              date_a;
  date_t              date_b;

  // combinational results
  logic [STAT_W-1:0]  stat_a_next;
  logic [STAT_W-1:0]  stat_b_next;
  logic [COUNT_W-1:0] count_a_next;
  logic [COUNT_W-1:0] count_b_next;
  logic [COUNT_W-1:0] diff_next;

  // the pipeline never holds off a transfer
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // config writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      year_floor   <= YEAR_FLOOR_RESET;
      current_year <= CURRENT_YEAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_YEAR_FLOOR:   year_floor   <= cfg_data;
        CFG_CURRENT_YEAR: current_year <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      date_a <= '{year: year_a, month: month_a, day: day_a};
      date_b <= '{year: year_b, month: month_b, day: day_b};
    end
  end

  // per-date checks and day numbers
  dvd_date_check u_check_a (
    .date         (date_a),
    .year_floor   (year_floor),
    .current_year (current_year),
    .status       (stat_a_next)
  );

  dvd_date_check u_check_b (
    .date         (date_b),
    .year_floor   (year_floor),
    .current_year (current_year),
    .status       (stat_b_next)
  );

  dvd_day_count u_count_a (
    .date  (date_a),
    .count (count_a_next)
  );

  dvd_day_count u_count_b (
    .date  (date_b),
    .count (count_b_next)
  );

  // modulo 2^23 difference equals the low bits of the exact one
  assign diff_next = count_a_next - count_b_next;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      status_a       <= stat_a_next;
      status_b       <= stat_b_next;
      day_count_a    <= $signed(count_a_next);
      day_count_b    <= $signed(count_b_next);
      day_difference <= $signed(diff_next);
    end
  end

`ifndef SYNTH
  // every registered item shows up as a result in the following cycle
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("registered item produced no result");

  // no result without an item behind it
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid))
    else $error("result strobe without a registered item");

  // difference matches the two day numbers shown with it
  a_diff_consistent: assert property (@(posedge clk) disable iff (rst)
    done |-> (day_difference == day_count_a - day_count_b))
    else $error("day difference does not match the day numbers");

  // a write to index 0 lands in the lowest valid year
  a_cfg_year_floor: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == CFG_YEAR_FLOOR)) |=>
      (year_floor == $past(cfg_data)))
    else $error("year floor write lost");
`endif

endmodule
`default_nettype wire

>>> src/dvd_date_check.sv
// year, month and day range check of one date
`default_nettype none
module dvd_date_check
  import dvd_pkg::*;
(
  input  date_t               date,
  input  logic [YEAR_W-1:0]   year_floor,
  input  logic [YEAR_W-1:0]   current_year,
  output logic [STAT_W-1:0]   status
);

  logic [PROD_W-1:0]  prod;
  logic [Q100_W-1:0]  q100;
  logic [YEAR_W:0]    q_times_100;
  logic [YEAR_W:0]    year_high;
  logic               div100;
  logic               leap;
  logic [LEN_W-1:0]   len;

  always_comb begin
    prod        = {{YEAR_W{1'b0}}, date.year} * {{YEAR_W{1'b0}}, RECIP_100};
    q100        = prod[RECIP_SHIFT +: Q100_W];
    q_times_100 = {{(YEAR_W + 1 - Q100_W){1'b0}}, q100} * 15'd100;
    div100      = ({1'b0, date.year} == q_times_100);
    // divisible by 4 and not by 100, or by 400
    leap        = ((date.year[1:0] == 2'd0) && !div100) || (div100 && (q100[1:0] == 2'd0));
    len         = month_length(date.month);
    if ((date.month == 4'd2) && leap) begin
      len = 5'd29;
    end
    year_high   = {1'b0, current_year} + 15'd1;

    if ((date.year < year_floor) || ({1'b0, date.year} > year_high)) begin
      status = STATUS_BAD_YEAR;
    end else if (!(date.month inside {[4'd1:4'd12]})) begin
      status = STATUS_BAD_MONTH;
    end else if ((date.day == 5'd0) || (date.day > len)) begin
      status = STATUS_BAD_DAY;
    end else begin
      status = STATUS_OK;
    end
  end

endmodule
`default_nettype wire

>>> src/dvd_day_count.sv
// day number of one date, counted from 0001-01-01 as day 1
`default_nettype none
module dvd_day_count
  import dvd_pkg::*;
(
  input  date_t               date,
  output logic [COUNT_W-1:0]  count
);

  logic               shift_year;
  logic               year_neg;
  logic [YEAR_W-1:0]  ty;
  logic [PROD_W-1:0]  prod;
  logic [Q100_W-1:0]  q100;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] years_part;

  // all sums are modulo 2^23, which gives the low bits of the exact value
  always_comb begin
    shift_year = (date.month < 4'd3);
    year_neg   = shift_year && (date.year == '0);
    ty         = shift_year ? (date.year - 14'd1) : date.year;
    prod       = {{YEAR_W{1'b0}}, ty} * {{YEAR_W{1'b0}}, RECIP_100};
    q100       = prod[RECIP_SHIFT +: Q100_W];
    base       = {{(COUNT_W - YEAR_W){1'b0}}, ty} * 23'd365;
    // shifted year of minus one: every truncating quotient is zero
    if (year_neg) begin
      years_part = 23'd0 - 23'd365;
    end else begin
      years_part = base
                 + {{(COUNT_W - YEAR_W + 2){1'b0}}, ty[YEAR_W-1:2]}
                 - {{(COUNT_W - Q100_W){1'b0}}, q100}
                 + {{(COUNT_W - Q100_W + 2){1'b0}}, q100[Q100_W-1:2]};
    end
    count = years_part
          + {{(COUNT_W - OFFS_W){1'b0}}, month_offset(date.month)}
          + {{(COUNT_W - DAY_W){1'b0}}, date.day}
          - 23'd306;
  end

endmodule
`default_nettype wire

>>> tb/sv/date_validate_and_day_number_tb.sv
// self-checking testbench for the date pair check and day number block
`timescale 1ns / 1ps
module date_validate_and_day_number_tb;
  import dvd_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int LIMIT_CYCLES = 200000;
  localparam int YEAR_MAX     = (1 << YEAR_W) - 1;
  localparam int PHASE_ITEMS  = 92;

  // index with no register behind it, writes there must change nothing
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd2;

  // one date pair, with statuses and day numbers optionally typed in by hand
  typedef struct {
    date_t                     a;
    date_t                     b;
    bit                        st_typed;
    logic [STAT_W-1:0]         st_a;
    logic [STAT_W-1:0]         st_b;
    bit                        cnt_typed;
    logic signed [COUNT_W-1:0] cnt_a;
    logic signed [COUNT_W-1:0] cnt_b;
    logic signed [COUNT_W-1:0] diff;
  } date_pair_t;

  // what one result transfer must carry
  typedef struct {
    logic [STAT_W-1:0]         st_a;
    logic [STAT_W-1:0]         st_b;
    logic signed [COUNT_W-1:0] cnt_a;
    logic signed [COUNT_W-1:0] cnt_b;
    logic signed [COUNT_W-1:0] diff;
  } date_outcome_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [YEAR_W-1:0]         year_a;
  logic [MONTH_W-1:0]        month_a;
  logic [DAY_W-1:0]          day_a;
  logic [YEAR_W-1:0]         year_b;
  logic [MONTH_W-1:0]        month_b;
  logic [DAY_W-1:0]          day_b;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index;
  logic [YEAR_W-1:0]         cfg_data;
  logic                      done;
  logic [STAT_W-1:0]         status_a;
  logic [STAT_W-1:0]         status_b;
  logic signed [COUNT_W-1:0] day_count_a;
  logic signed [COUNT_W-1:0] day_count_b;
  logic signed [COUNT_W-1:0] day_difference;

  // checker copy of the year window registers
  int year_floor_cfg   = int'(YEAR_FLOOR_RESET);
  int current_year_cfg = int'(CURRENT_YEAR_RESET);

  date_outcome_t pending_outcomes[$];
  date_pair_t    directed_pairs[$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            burst_left     = 0;

  date_validate_and_day_number u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .year_a         (year_a),
    .month_a        (month_a),
    .day_a          (day_a),
    .year_b         (year_b),
    .month_b        (month_b),
    .day_b          (day_b),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .status_a       (status_a),
    .status_b       (status_b),
    .day_count_a    (day_count_a),
    .day_count_b    (day_count_b),
    .day_difference (day_difference)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // calendar arithmetic for the checker
  // ---------------------------------------------------------------------------

  // divisible by 4 but not 100, or divisible by 400
  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // month length, the leap day only in february; bad months read as 31
  function automatic int month_days(int y, int m);
    case (m)
      2:             return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // year window first, then month, then day against the month length
  function automatic logic [STAT_W-1:0] date_status(date_t dt);
    int y;
    int m;
    int d;
    y = int'(dt.year);
    m = int'(dt.month);
    d = int'(dt.day);
    if (y < year_floor_cfg || y > current_year_cfg + 1)
      return STATUS_BAD_YEAR;
    if (m < 1 || m > 12)
      return STATUS_BAD_MONTH;
    if (d < 1 || d > month_days(y, m))
      return STATUS_BAD_DAY;
    return STATUS_OK;
  endfunction

  // days since 0001-01-01 (that day is 1), year starting in march;
  // signed division truncates toward zero, which matters for year zero
  function automatic longint day_serial(date_t dt);
    longint yr;
    longint mo;
    yr = longint'(dt.year);
    mo = longint'(dt.month);
    if (mo < 3) begin
      yr = yr - 1;
      mo = mo + 12;
    end
    return 365 * yr + yr / 4 - yr / 100 + yr / 400 + (153 * mo - 457) / 5
           + longint'(dt.day) - 306;
  endfunction

  // expected result for one pair; hand-typed values win over computed ones
  function automatic date_outcome_t date_pair_outcome(date_pair_t p);
    date_outcome_t o;
    longint        na;
    longint        nb;
    longint        nd;
    na = day_serial(p.a);
    nb = day_serial(p.b);
    nd = na - nb;
    o.st_a  = date_status(p.a);
    o.st_b  = date_status(p.b);
    // out-of-range years wrap to the low 23 bits
    o.cnt_a = na[COUNT_W-1:0];
    o.cnt_b = nb[COUNT_W-1:0];
    o.diff  = nd[COUNT_W-1:0];
    if (p.st_typed) begin
      o.st_a = p.st_a;
      o.st_b = p.st_b;
    end
    if (p.cnt_typed) begin
      o.cnt_a = p.cnt_a;
      o.cnt_b = p.cnt_b;
      o.diff  = p.diff;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  function automatic date_pair_t mk_pair(int ya, int ma, int da, int yb, int mb, int db,
                                         bit st_typed = 1'b0,
                                         logic [STAT_W-1:0] sa = STATUS_OK,
                                         logic [STAT_W-1:0] sb = STATUS_OK,
                                         bit cnt_typed = 1'b0,
                                         int ca = 0, int cb = 0, int df = 0);
    date_pair_t p;
    p.a.year   = ya[YEAR_W-1:0];
    p.a.month  = ma[MONTH_W-1:0];
    p.a.day    = da[DAY_W-1:0];
    p.b.year   = yb[YEAR_W-1:0];
    p.b.month  = mb[MONTH_W-1:0];
    p.b.day    = db[DAY_W-1:0];
    p.st_typed  = st_typed;
    p.st_a      = sa;
    p.st_b      = sb;
    p.cnt_typed = cnt_typed;
    p.cnt_a     = ca[COUNT_W-1:0];
    p.cnt_b     = cb[COUNT_W-1:0];
    p.diff      = df[COUNT_W-1:0];
    return p;
  endfunction

  // mostly dates near the year window and month ends, some raw noise
  function automatic date_t pick_date();
    date_t       dt;
    logic [31:0] rnd;
    int          y;
    int          m;
    int          d;
    int          len;
    if ($urandom_range(0, 6) == 0) begin
      rnd = $urandom;
      dt  = rnd[$bits(date_t)-1:0];
      return dt;
    end
    case ($urandom_range(0, 9))
      0:       y = year_floor_cfg - 1;
      1:       y = year_floor_cfg;
      2:       y = current_year_cfg + 1;
      3:       y = current_year_cfg + 2;
      8:       y = $urandom_range(0, YEAR_MAX);
      9:       y = 100 * $urandom_range(0, 163);     // century years, leap rule corners
      default: y = $urandom_range(year_floor_cfg, current_year_cfg + 1);
    endcase
    if (y < 0)
      y = 0;
    if (y > YEAR_MAX)
      y = YEAR_MAX;
    if ($urandom_range(0, 9) == 0)
      m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
    else
      m = $urandom_range(1, 12);
    len = month_days(y, m);
    case ($urandom_range(0, 7))
      0:       d = len;
      1:       d = (len < 31) ? len + 1 : 31;
      2:       d = 0;
      3:       d = $urandom_range(0, 31);
      default: d = $urandom_range(1, len);
    endcase
    dt.year  = y[YEAR_W-1:0];
    dt.month = m[MONTH_W-1:0];
    dt.day   = d[DAY_W-1:0];
    return dt;
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t p;
    p = mk_pair(0, 0, 0, 0, 0, 0);
    p.a = pick_date();
    // sometimes b sits right next to a, small differences around zero
    if ($urandom_range(0, 4) == 0) begin
      p.b = p.a;
      p.b.day = p.a.day + DAY_W'($urandom_range(0, 2)) - 5'd1;
    end else begin
      p.b = pick_date();
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers: inputs change on the falling edge
  // ---------------------------------------------------------------------------

  // command transfer, sent in bursts with idle gaps in between
  task automatic send_pair(date_pair_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      // now and then a long stretch with no idle cycle at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    @(negedge clk);
    year_a  = p.a.year;
    month_a = p.a.month;
    day_a   = p.a.day;
    year_b  = p.b.year;
    month_b = p.b.month;
    day_b   = p.b.day;
    directed_pairs.push_front(p);   // slot 0 holds the pair now on the bus
    if (directed_pairs.size() > 1)
      void'(directed_pairs.pop_back());
    start = 1'b1;
    do @(posedge clk); while (busy);
    burst_left--;
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value[YEAR_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop sending and wait for every outstanding result, then a little slack
  task automatic drain();
    @(negedge clk);
    start      = 1'b0;
    burst_left = 0;
    while (pending_outcomes.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) send_pair(random_pair());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // checking: outputs sampled on the rising edge
  // ---------------------------------------------------------------------------

  task automatic check_field(string fld, logic signed [COUNT_W-1:0] exp_v,
                             logic signed [COUNT_W-1:0] got_v);
    if (got_v !== exp_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fld, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    date_outcome_t exp_o;
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("date_validate_and_day_number_tb: FAIL");
      $finish;
    end
    if (!rst) begin
      // result transfer: the receiver never stalls, one result per done cycle
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transfer with nothing expected", $time);
        end else begin
          exp_o = pending_outcomes.pop_front();
          check_field("status_a", {21'd0, exp_o.st_a}, {21'd0, status_a});
          check_field("status_b", {21'd0, exp_o.st_b}, {21'd0, status_b});
          check_field("day_count_a", exp_o.cnt_a, day_count_a);
          check_field("day_count_b", exp_o.cnt_b, day_count_b);
          check_field("day_difference", exp_o.diff, day_difference);
        end
      end
      // command transfer, predicted with the register values in force now
      if (start && !busy)
        pending_outcomes.push_back(date_pair_outcome(directed_pairs[0]));
      // register write transfer; unused indexes change nothing
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_YEAR_FLOOR:   year_floor_cfg   = int'(cfg_data);
          CFG_CURRENT_YEAR: current_year_cfg = int'(cfg_data);
          default:          ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    date_pair_t rows[$];
    rst       = 1'b1;
    start     = 1'b0;
    year_a    = '0;
    month_a   = '0;
    day_a     = '0;
    year_b    = '0;
    month_b   = '0;
    day_b     = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_YEAR_FLOOR;
    cfg_data  = '0;
    directed_pairs.push_back(mk_pair(0, 0, 0, 0, 0, 0));

    // directed pairs under the reset window 1500..2024
    // first day of the calendar, both below the window
    rows.push_back(mk_pair(1, 1, 1, 1, 1, 1, 1'b1, STATUS_BAD_YEAR, STATUS_BAD_YEAR,
                           1'b1, 1, 1, 0));
    // leap day in a 400 year vs a century year that is not leap
    rows.push_back(mk_pair(2000, 2, 29, 1900, 2, 29, 1'b1, STATUS_OK, STATUS_BAD_DAY));
    // top of the window and one past it
    rows.push_back(mk_pair(2024, 12, 31, 2025, 1, 1, 1'b1, STATUS_OK, STATUS_BAD_YEAR));
    // bottom of the window and one below it
    rows.push_back(mk_pair(1500, 1, 1, 1499, 12, 31, 1'b1, STATUS_OK, STATUS_BAD_YEAR));
    // month zero and thirteen
    rows.push_back(mk_pair(2020, 0, 15, 2020, 13, 1, 1'b1, STATUS_BAD_MONTH,
                           STATUS_BAD_MONTH));
    // month fifteen, day zero
    rows.push_back(mk_pair(2020, 15, 31, 2020, 12, 0, 1'b1, STATUS_BAD_MONTH,
                           STATUS_BAD_DAY));
    rows.push_back(mk_pair(2021, 4, 31, 2021, 4, 30, 1'b1, STATUS_BAD_DAY, STATUS_OK));
    rows.push_back(mk_pair(2004, 2, 29, 2023, 2, 29, 1'b1, STATUS_OK, STATUS_BAD_DAY));
    rows.push_back(mk_pair(2020, 1, 31, 2020, 6, 31, 1'b1, STATUS_OK, STATUS_BAD_DAY));
    // all-ones fields vs year zero
    rows.push_back(mk_pair(YEAR_MAX, 15, 31, 0, 1, 1, 1'b1, STATUS_BAD_YEAR,
                           STATUS_BAD_YEAR));
    // year zero in february, and a day number past the signed 23-bit range
    rows.push_back(mk_pair(0, 2, 28, YEAR_MAX, 1, 1, 1'b1, STATUS_BAD_YEAR,
                           STATUS_BAD_YEAR));
    // last day of year 9999 against the first day, both ways round
    rows.push_back(mk_pair(9999, 12, 31, 1, 1, 1, 1'b1, STATUS_BAD_YEAR, STATUS_BAD_YEAR,
                           1'b1, 3652059, 1, 3652058));
    rows.push_back(mk_pair(1, 1, 1, 9999, 12, 31, 1'b1, STATUS_BAD_YEAR, STATUS_BAD_YEAR,
                           1'b1, 1, 3652059, -3652058));
    rows.push_back(mk_pair(2020, 2, 29, 2024, 2, 29, 1'b1, STATUS_OK, STATUS_OK));
    rows.push_back(mk_pair(1600, 2, 29, 1700, 2, 29, 1'b1, STATUS_OK, STATUS_BAD_DAY));
    rows.push_back(mk_pair(2023, 3, 1, 2023, 2, 28, 1'b1, STATUS_OK, STATUS_OK));
    rows.push_back(mk_pair(2023, 11, 31, 2023, 9, 30, 1'b1, STATUS_BAD_DAY, STATUS_OK));
    // everything zero in b, day zero of january in a
    rows.push_back(mk_pair(2023, 1, 0, 0, 0, 0, 1'b1, STATUS_BAD_DAY, STATUS_BAD_YEAR));
    rows.push_back(mk_pair(2024, 7, 31, 2024, 14, 31, 1'b1, STATUS_OK, STATUS_BAD_MONTH));
    rows.push_back(mk_pair(2023, 10, 31, 2023, 5, 31, 1'b1, STATUS_OK, STATUS_OK));
    // computed-only rows: leap years at the far end and month 14 of year zero
    rows.push_back(mk_pair(8000, 2, 29, 0, 14, 3));
    rows.push_back(mk_pair(10000, 13, 17, 4, 0, 31));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // phase 0: reset window, directed table then random pairs
    foreach (rows[i])
      send_pair(rows[i]);
    run_random(PHASE_ITEMS);

    // phase 1: widest legal window
    cfg_write(CFG_YEAR_FLOOR, 1);
    cfg_write(CFG_CURRENT_YEAR, 9998);
    run_random(PHASE_ITEMS);

    // phase 2: only year 9999 is in the window
    cfg_write(CFG_YEAR_FLOOR, 9999);
    run_random(PHASE_ITEMS);

    // phase 3: narrowest low window, years 1 and 2
    cfg_write(CFG_YEAR_FLOOR, 1);
    cfg_write(CFG_CURRENT_YEAR, 1);
    run_random(PHASE_ITEMS);

    // phase 4: write to an unused index, then a random legal window
    cfg_write(CFG_UNUSED, $urandom_range(0, YEAR_MAX));
    cfg_write(CFG_YEAR_FLOOR, $urandom_range(1, 9999));
    cfg_write(CFG_CURRENT_YEAR, $urandom_range(1, 9998));
    run_random(PHASE_ITEMS);

    // phase 5: raw 14-bit register values, window may be empty or past 9999
    cfg_write(CFG_CURRENT_YEAR, $urandom_range(0, YEAR_MAX));
    cfg_write(CFG_YEAR_FLOOR, $urandom_range(0, YEAR_MAX));
    run_random(PHASE_ITEMS);

    // all results in and the pipeline flushed
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("date_validate_and_day_number_tb: PASS");
    else
      $display("date_validate_and_day_number_tb: FAIL");
    $finish;
  end

endmodule

>>> sim.f
src/dvd_pkg.sv
src/dvd_date_check.sv
src/dvd_day_count.sv
src/date_validate_and_day_number.sv
tb/sv/date_validate_and_day_number_tb.sv
